FILE: hdl/gsil_pkg.sv
// Shared types, codes and constants for the grouped sorted insert lists block.
`timescale 1ns / 1ps

package gsil_pkg;

   // Field widths fixed by the item formats.
   localparam int AGE_W  = 7;
   localparam int SEX_W  = 2;
   localparam int STAT_W = 2;
   localparam int GRP_W  = 2;

   // Number of age groups and the default slot count per group.
   localparam int NUM_GROUPS        = 3;
   localparam int GROUP_DEPTH_DEF   = 16;

   // Configuration register file.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_TEEN_LIMIT = 1'b0;
   localparam logic [AGE_W-1:0] TEEN_LIMIT_RST = 7'd19;

   // Command codes.
   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_READOUT = 1'b1;

   // Sex code that selects the men's group.
   localparam logic [SEX_W-1:0] SEX_MALE = 2'd1;

   // Result status codes.
   localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_ENTRY    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

   // Group codes.
   localparam logic [GRP_W-1:0] GRP_YOUTH = 2'd0;
   localparam logic [GRP_W-1:0] GRP_WOMEN = 2'd1;
   localparam logic [GRP_W-1:0] GRP_MEN   = 2'd2;

   // Input transaction payload.
   typedef struct packed {
      logic             cmd;
      logic [AGE_W-1:0] age;
      logic [SEX_W-1:0] sex;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [GRP_W-1:0]  group;
      logic [AGE_W-1:0]  age_out;
      logic              last;
   } rsp_type;

endpackage

FILE: hdl/gsil_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module gsil_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/grouped_sorted_insert_lists_top.sv
// Top level of the grouped sorted insert lists block.
`timescale 1ns / 1ps

// Keeps three ascending lists of ages (youth, women, men) of GROUP_DEPTH slots
// each in one synchronous RAM. One transaction is worked at a time. An insert
// walks its group from the tail, moving each larger-or-equal age up one slot
// per cycle, then writes the new age into the open slot (the head slot when
// every age moved); a full group answers straight away, an empty one once the
// age is in its head slot. A readout of an empty store gives one empty status;
// else one stored age per cycle from the single read port, unless results stall.
// Results leave through an output register, so a stall on the result side
// only holds the sequencer when the next result is ready. The age limit
// register should be written only while the block is idle.
module grouped_sorted_insert_lists_top #(
   parameter int GROUP_DEPTH = gsil_pkg::GROUP_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  gsil_pkg::req_type                    req_data,
   // Result channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output gsil_pkg::rsp_type                    rsp_data,
   // Configuration port.
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [gsil_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [gsil_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [gsil_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   import gsil_pkg::*;

   localparam int MEM_DEPTH = NUM_GROUPS * GROUP_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int CNT_W     = $clog2(GROUP_DEPTH + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_INS  = 5'b00010,
      ST_HEAD = 5'b00100,
      ST_RESP = 5'b01000,
      ST_RO   = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [GRP_W-1:0]     grp_ff, grp_in;
   logic [AGE_W-1:0]     age_ff, age_in;
   logic [CNT_W-1:0]     cur_ff, cur_in;
   logic [STAT_W-1:0]    stat_ff, stat_in;
   logic [CNT_W-1:0]     count_ff [NUM_GROUPS];
   logic [CNT_W-1:0]     count_in [NUM_GROUPS];
   logic [AGE_W-1:0]     limit_ff, limit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [AGE_W-1:0]     mem_wr_data;
   logic                 mem_rd_en;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic [AGE_W-1:0]     mem_rd_data;

   logic                 req_acc;
   logic                 out_free;
   logic                 csr_wr;
   logic [GRP_W-1:0]     ins_grp;
   logic [CNT_W-1:0]     ins_cnt;
   logic [CNT_W-1:0]     cur_cnt;
   logic [NUM_GROUPS-1:0] nonempty;
   logic [GRP_W-1:0]     first_grp;
   logic                 has_next;
   logic [GRP_W-1:0]     next_grp;
   logic                 ro_last;
   logic                 ro_grp_end;

   // Slot address of entry idx within group g.
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [GRP_W-1:0] g,
                                                    input logic [CNT_W-1:0] idx);
      int full;
      full = int'(g) * GROUP_DEPTH + int'(idx);
      return full[ADDR_W-1:0];
   endfunction

   // Count of one group, selected by its code.
   function automatic logic [CNT_W-1:0] count_of(input logic [GRP_W-1:0] g,
                                                  input logic [CNT_W-1:0] c0,
                                                  input logic [CNT_W-1:0] c1,
                                                  input logic [CNT_W-1:0] c2);
      logic [CNT_W-1:0] r;
      unique case (g)
         GRP_YOUTH: r = c0;
         GRP_WOMEN: r = c1;
         default:   r = c2;
      endcase
      return r;
   endfunction

   // Age store.
   gsil_ram #(
      .WIDTH (AGE_W),
      .DEPTH (MEM_DEPTH)
   ) u_ages (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Handshakes and configuration port.
   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite && (paddr[2:2] == REG_TEEN_LIMIT);
   assign prdata    = (paddr[2:2] == REG_TEEN_LIMIT) ?
                      {{(CSR_DATA_W - AGE_W){1'b0}}, limit_ff} : '0;
   assign limit_in  = csr_wr ? pwdata[AGE_W-1:0] : limit_ff;

   // Group selection for an incoming insert.
   always_comb begin
      if (req_data.age < limit_ff) begin
         ins_grp = GRP_YOUTH;
      end else if (req_data.sex == SEX_MALE) begin
         ins_grp = GRP_MEN;
      end else begin
         ins_grp = GRP_WOMEN;
      end
   end

   assign ins_cnt = count_of(ins_grp, count_ff[0], count_ff[1], count_ff[2]);
   assign cur_cnt = count_of(grp_ff, count_ff[0], count_ff[1], count_ff[2]);

   // Readout walk: which groups hold entries and where the walk goes next.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         nonempty[g] = (count_ff[g] != '0);
      end
      if (nonempty[0]) begin
         first_grp = GRP_YOUTH;
      end else if (nonempty[1]) begin
         first_grp = GRP_WOMEN;
      end else begin
         first_grp = GRP_MEN;
      end
      if ((grp_ff == GRP_YOUTH) && nonempty[1]) begin
         has_next = 1'b1;
         next_grp = GRP_WOMEN;
      end else if ((grp_ff != GRP_MEN) && nonempty[2]) begin
         has_next = 1'b1;
         next_grp = GRP_MEN;
      end else begin
         has_next = 1'b0;
         next_grp = GRP_MEN;
      end
      ro_grp_end = ((cur_ff + 1'b1) == cur_cnt);
      ro_last    = ro_grp_end && !has_next;
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      grp_in       = grp_ff;
      age_in       = age_ff;
      cur_in       = cur_ff;
      stat_in      = stat_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = slot_addr(grp_ff, cur_ff);
      mem_wr_data  = age_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = slot_addr(grp_ff, cur_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_data.cmd == CMD_INSERT) begin
                  grp_in = ins_grp;
                  age_in = req_data.age;
                  if (ins_cnt >= CNT_W'(GROUP_DEPTH)) begin
                     stat_in  = STAT_FULL;
                     state_in = ST_RESP;
                  end else begin
                     stat_in           = STAT_INSERTED;
                     count_in[ins_grp] = ins_cnt + 1'b1;
                     if (ins_cnt == '0) begin
                        // Empty group: the age goes straight to the head slot.
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = slot_addr(ins_grp, '0);
                        mem_wr_data = req_data.age;
                        state_in    = ST_RESP;
                     end else begin
                        // Start at the tail of the group.
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = slot_addr(ins_grp, ins_cnt - 1'b1);
                        cur_in      = ins_cnt;
                        state_in    = ST_INS;
                     end
                  end
               end else begin
                  if (nonempty == '0) begin
                     stat_in  = STAT_EMPTY;
                     grp_in   = GRP_YOUTH;
                     state_in = ST_RESP;
                  end else begin
                     grp_in      = first_grp;
                     cur_in      = '0;
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = slot_addr(first_grp, '0);
                     state_in    = ST_RO;
                  end
               end
            end
         end

         ST_INS: begin
            // The read data is the entry just below the open slot.
            mem_wr_en = 1'b1;
            if (mem_rd_data >= age_ff) begin
               mem_wr_data = mem_rd_data;
               if (cur_ff == CNT_W'(1)) begin
                  state_in = ST_HEAD;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = slot_addr(grp_ff, cur_ff - CNT_W'(2));
                  cur_in      = cur_ff - 1'b1;
               end
            end else begin
               mem_wr_data = age_ff;
               state_in    = ST_RESP;
            end
         end

         ST_HEAD: begin
            // Every stored age moved up: the new age becomes the head.
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot_addr(grp_ff, '0);
            mem_wr_data = age_ff;
            state_in    = ST_RESP;
         end

         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.status  = stat_ff;
               rsp_data_in.group   = grp_ff;
               rsp_data_in.age_out = '0;
               rsp_data_in.last    = 1'b1;
               state_in            = ST_IDLE;
            end
         end

         ST_RO: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.status  = STAT_ENTRY;
               rsp_data_in.group   = grp_ff;
               rsp_data_in.age_out = mem_rd_data;
               rsp_data_in.last    = ro_last;
               if (ro_last) begin
                  state_in = ST_IDLE;
               end else if (ro_grp_end) begin
                  grp_in      = next_grp;
                  cur_in      = '0;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = slot_addr(next_grp, '0);
               end else begin
                  cur_in      = cur_ff + 1'b1;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = slot_addr(grp_ff, cur_ff + 1'b1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= TEEN_LIMIT_RST;
         for (int g = 0; g < NUM_GROUPS; g++) begin
            count_ff[g] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      grp_ff      <= grp_in;
      age_ff      <= age_in;
      cur_ff      <= cur_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
